>>> rtl/indexed_list_insert_erase_unit_assert.svh
// Assertion macros for the positional list insert/erase unit.
// Used by the top level; needs no package.
`ifndef INDEXED_LIST_INSERT_ERASE_UNIT_ASSERT_SVH
`define INDEXED_LIST_INSERT_ERASE_UNIT_ASSERT_SVH

`ifndef SYNTH
`define ILIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ILIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ILIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ILIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/ilie_pkg.sv
// Shared types for the positional list insert/erase unit:
// status codes, request modes and the controller/datapath command and status words.
`default_nettype none
package ilie_pkg;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_ERASE  = 1'b1;

  typedef struct packed {
    logic load;
    logic move;
    logic commit;
    logic scan;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic out_free;
  } ctl_sts_t;

endpackage
`default_nettype wire

>>> rtl/ilie_if.sv
// Valid/ready channel interfaces for the request and result words.
// Standalone; widths are set by the instantiating level.
`default_nettype none
interface ilie_req_if #(
  parameter int POS_W  = 7,
  parameter int DATA_W = 16
) ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink (input valid, input mode, input position, input value, output ready);
endinterface

interface ilie_rsp_if #(
  parameter int CNT_W  = 7,
  parameter int DATA_W = 16
) ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [CNT_W-1:0]         count;
  logic signed [DATA_W-1:0] max_value;
  logic                     ascending;

  modport source (output valid, output status, output count, output max_value,
                  output ascending, input ready);
  modport sink (input valid, input status, input count, input max_value,
                input ascending, output ready);
endinterface
`default_nettype wire

>>> rtl/ilie_ctrl.sv
// Sequencing state machine: accept, shift, commit, scan, deliver.
// Depends on ilie_pkg for the command and status words.
`default_nettype none
module ilie_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ilie_pkg::ctl_sts_t sts,
  output ilie_pkg::ctl_cmd_t     cmd
);
  import ilie_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MOVE   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_SCAN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        cmd.move = 1'b1;
        if (sts.walk_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.walk_done && sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/ilie_dp.sv
// Datapath: entry memory, shift and scan walker, length, max/order accumulators, result register.
// Depends on ilie_pkg; driven by ilie_ctrl commands.
`default_nettype none
module ilie_dp #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16,
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ilie_pkg::ctl_cmd_t            cmd,
  output ilie_pkg::ctl_sts_t                 sts,
  input  wire logic                          in_mode,
  input  wire logic [CW-1:0]                 in_position,
  input  wire logic signed [DATA_WIDTH-1:0]  in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_status,
  output logic [CW-1:0]                      out_count,
  output logic signed [DATA_WIDTH-1:0]       out_max_value,
  output logic                               out_ascending
);
  import ilie_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  logic                         mode_r;
  logic [CW-1:0]                pos_r;
  logic signed [DATA_WIDTH-1:0] val_r;
  status_t                      stat_r;
  logic [CW-1:0]                len_r;
  logic [AW-1:0]                idx_r;
  logic [AW-1:0]                last_r;
  logic [CW-1:0]                cnt_r;
  logic                         rv_r;
  logic signed [DATA_WIDTH-1:0] rdata_r;
  logic signed [DATA_WIDTH-1:0] max_r;
  logic signed [DATA_WIDTH-1:0] prev_r;
  logic                         asc_r;
  logic                         first_r;
  logic                         ov_r;
  status_t                      ostat_r;
  logic [CW-1:0]                ocount_r;
  logic signed [DATA_WIDTH-1:0] omax_r;
  logic                         oasc_r;

  status_t                      req_stat;
  logic                         ok;
  logic [CW-1:0]                len_nxt;
  logic                         walking;
  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic signed [DATA_WIDTH-1:0] wr_data;

  always_comb begin
    if (in_position > len_r) begin
      req_stat = ST_ILLEGAL;
    end else if (in_mode == MODE_ERASE) begin
      req_stat = (in_position == len_r) ? ST_ILLEGAL : ST_DONE;
    end else begin
      req_stat = (len_r == CW'(DEPTH)) ? ST_FULL : ST_DONE;
    end
  end

  assign ok      = (stat_r == ST_DONE);
  assign len_nxt = !ok ? len_r :
                   (mode_r == MODE_INSERT) ? len_r + CW'(1) : len_r - CW'(1);
  assign walking = (cmd.move || cmd.scan) && (cnt_r != '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = last_r;
    wr_data = rdata_r;
    if (cmd.move && rv_r) begin
      wr_en   = 1'b1;
      wr_addr = (mode_r == MODE_INSERT) ? last_r + AW'(1) : last_r - AW'(1);
    end else if (cmd.commit && ok && (mode_r == MODE_INSERT)) begin
      wr_en   = 1'b1;
      wr_addr = pos_r[AW-1:0];
      wr_data = val_r;
    end
  end

  assign sts.walk_done = (cnt_r == '0) && !rv_r;
  assign sts.out_free  = !ov_r || out_ready;

  always_ff @(posedge clk) begin
    if (wr_en)   mem[wr_addr] <= wr_data;
    if (walking) rdata_r      <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cnt_r <= '0;
      rv_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        mode_r <= in_mode;
        pos_r  <= in_position;
        val_r  <= in_value;
        stat_r <= req_stat;
        rv_r   <= 1'b0;
        if (req_stat != ST_DONE) begin
          cnt_r <= '0;
        end else if (in_mode == MODE_INSERT) begin
          cnt_r <= len_r - in_position;
        end else begin
          cnt_r <= len_r - in_position - CW'(1);
        end
        if (in_mode == MODE_INSERT) idx_r <= AW'(len_r - CW'(1));
        else                        idx_r <= AW'(in_position + CW'(1));
      end

      if (cmd.move || cmd.scan) begin
        rv_r <= walking;
        if (walking) begin
          last_r <= idx_r;
          cnt_r  <= cnt_r - CW'(1);
          if (cmd.move && (mode_r == MODE_INSERT)) idx_r <= idx_r - AW'(1);
          else                                      idx_r <= idx_r + AW'(1);
        end
      end

      if (cmd.scan && rv_r) begin
        if (first_r || (rdata_r > max_r)) max_r <= rdata_r;
        if (!first_r && (prev_r > rdata_r)) asc_r <= 1'b0;
        prev_r  <= rdata_r;
        first_r <= 1'b0;
      end

      if (cmd.commit) begin
        len_r   <= len_nxt;
        idx_r   <= '0;
        cnt_r   <= len_nxt;
        max_r   <= '1;
        first_r <= 1'b1;
        asc_r   <= 1'b1;
      end

      if (cmd.emit) begin
        ov_r     <= 1'b1;
        ostat_r  <= stat_r;
        ocount_r <= len_r;
        omax_r   <= max_r;
        oasc_r   <= asc_r;
      end else if (ov_r && out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid     = ov_r;
  assign out_status    = ostat_r;
  assign out_count     = ocount_r;
  assign out_max_value = omax_r;
  assign out_ascending = oasc_r;

endmodule
`default_nettype wire

>>> rtl/indexed_list_insert_erase_unit.sv
// Top level of the positional list insert/erase unit.
// Depends on ilie_pkg, ilie_if, ilie_ctrl, ilie_dp and the assertion macro header.
//
//   channel   | dir | word fields
//   ----------+-----+-------------------------------------------
//   in_req    | in  | mode, position, value
//   out_rsp   | out | status, count, max_value, ascending
//
// One request at a time. Its shift walks M entries (L - P on insert, L - P - 1 on
// erase, 0 when rejected) through the single read port of the entry memory; the
// scan then reads all L' entries after the request the same way before the result
// word is loaded. The controller returns to idle, ready for the next request, at
// the same edge that loads the result word. Reset clears the length and the result
// valid; entry contents start undefined. A stalled result holds the next request
// in its last scan cycle.
`default_nettype none
`include "indexed_list_insert_erase_unit_assert.svh"
module indexed_list_insert_erase_unit #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16
) (
  input wire logic   clk,
  input wire logic   rst_n,
  ilie_req_if.sink   in_req,
  ilie_rsp_if.source out_rsp
);
  import ilie_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ilie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ilie_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CW         (CW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_req.mode),
    .in_position   (in_req.position),
    .in_value      (in_req.value),
    .out_valid     (out_rsp.valid),
    .out_ready     (out_rsp.ready),
    .out_status    (out_rsp.status),
    .out_count     (out_rsp.count),
    .out_max_value (out_rsp.max_value),
    .out_ascending (out_rsp.ascending)
  );

  `ILIE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready, "ready stayed high after accept")
  `ILIE_ASSERT_IMP(a_rise_from_emit, clk, rst_n, $rose(out_rsp.valid), $past(cmd.emit), "result word without emit")
  `ILIE_ASSERT_IMP(a_empty_result, clk, rst_n, out_rsp.valid && (out_rsp.count == '0), (out_rsp.max_value == '1) && out_rsp.ascending, "bad empty-list result")

endmodule
`default_nettype wire
